FILE: rtl/core/sfc_pkg.sv
// Shared types and constants for the sphere frustum cull core.
// Depends on nothing; included by wildcard import in rtl/core modules.
package sfc_pkg;

    localparam int PLANE_REGS     = 6;
    localparam int NUM_PLANES_DEF = 6;

    localparam int COEF_W   = 16;
    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 15;
    localparam int INDEX_W  = 16;
    localparam int CFG_W    = 64;
    localparam int CFG_AW   = 3;

    // Q16.16 product of two Q8.8 values.
    localparam int PROD_W = 2 * COEF_W;
    // (d + r) needs one more bit than d.
    localparam int DR_W   = COEF_W + 1;
    // Full plane sum a*x + b*y + c*z + (d + r) * 256 with headroom.
    localparam int SUM_W  = PROD_W + 3;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    // One plane register, a in the low bits.
    typedef struct packed {
        logic [COEF_W-1:0] d;
        logic [COEF_W-1:0] c;
        logic [COEF_W-1:0] b;
        logic [COEF_W-1:0] a;
    } plane_t;

    // Input word layout, center_x in the low bits.
    typedef struct packed {
        logic                pad;
        logic [INDEX_W-1:0]  mesh_index;
        logic [RADIUS_W-1:0] radius;
        logic [COORD_W-1:0]  center_z;
        logic [COORD_W-1:0]  center_y;
        logic [COORD_W-1:0]  center_x;
    } s_word_t;

endpackage

FILE: rtl/core/sphere_frustum_cull_core.sv
// Bounding sphere versus view frustum test, four-stage pipeline.
// Depends on sfc_pkg (rtl/core/sfc_pkg.sv).
//
// Usage: spheres arrive as words on the s_ channel, one word per sphere. Each
// sphere is tested against planes 0 .. NUM_PLANES-1 held in 64-bit plane
// registers, written through the cfg_ port (index 0 .. 5; other indexes are
// ignored). A sphere is culled when a*x + b*y + c*z + d < -radius for any
// plane, computed exactly in Q16.16. Every sphere yields exactly one result
// word on the m_ channel: the visible flag in m_tuser and the mesh index,
// unchanged, in m_tdata.
//
// A sphere's result word passes through stage one, stage two, stage three and
// the output register before m_tvalid rises. Throughput is one sphere per
// cycle while the receiver takes results: stage one forms the three products
// and d + r per plane, stage two adds them in pairs, stage three forms the
// sign of the full sum, and the output register NORs the per-plane cull bits.
//
// Reset (aresetn low at a clock edge) empties the pipeline and clears all
// plane registers; with all-zero planes every sphere is visible. When the
// receiver stalls, a stage holds its word only if the next stage is full, so
// bubbles are squeezed out; s_tready drops only once all four stages hold words.
// Write planes only while the pipeline is empty; the block does not enforce it.
module sphere_frustum_cull_core
    import sfc_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_AW-1:0]    cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wr_data,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // center_x[15:0], center_y[31:16], center_z[47:32], radius[62:48],
    // mesh_index[78:63], zero[79]
    input  logic [S_TDATA_W-1:0] s_tdata,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_index[15:0]
    output logic [M_TDATA_W-1:0] m_tdata,
    // visible[0]
    output logic                 m_tuser
);

    // Plane registers.
    plane_t plane_reg [PLANE_REGS];

    always_ff @(posedge aclk) begin
        for (int i = 0; i < PLANE_REGS; i++) begin
            if (!aresetn) begin
                plane_reg[i] <= '0;
            end else if (cfg_wr_en && (cfg_addr == CFG_AW'(i))) begin
                plane_reg[i] <= plane_t'(cfg_wr_data);
            end
        end
    end

    // Stage valid bits and the ready chain. A stage may load when it is
    // empty or when its contents move on in the same cycle.
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdyo;

    assign rdyo     = !vo_reg || m_tready;
    assign rdy3     = !v3_reg || rdyo;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdyo) vo_reg <= v3_reg;
        end
    end

    // Stage one: per-plane products and (d + r).
    s_word_t in_word;
    assign in_word = s_word_t'(s_tdata);

    logic signed [PROD_W-1:0] px_next [NUM_PLANES];
    logic signed [PROD_W-1:0] py_next [NUM_PLANES];
    logic signed [PROD_W-1:0] pz_next [NUM_PLANES];
    logic signed [DR_W-1:0]   dr_next [NUM_PLANES];
    logic signed [PROD_W-1:0] px_reg  [NUM_PLANES];
    logic signed [PROD_W-1:0] py_reg  [NUM_PLANES];
    logic signed [PROD_W-1:0] pz_reg  [NUM_PLANES];
    logic signed [DR_W-1:0]   dr_reg  [NUM_PLANES];
    logic [INDEX_W-1:0]       idx1_reg;

    always_comb begin
        logic signed [COEF_W-1:0] ca, cb, cc, cd;
        logic signed [COORD_W-1:0] x, y, z;
        logic signed [DR_W-1:0] r;
        x = signed'(in_word.center_x);
        y = signed'(in_word.center_y);
        z = signed'(in_word.center_z);
        r = signed'({2'b00, in_word.radius});
        for (int p = 0; p < NUM_PLANES; p++) begin
            ca = signed'(plane_reg[p].a);
            cb = signed'(plane_reg[p].b);
            cc = signed'(plane_reg[p].c);
            cd = signed'(plane_reg[p].d);
            px_next[p] = ca * x;
            py_next[p] = cb * y;
            pz_next[p] = cc * z;
            dr_next[p] = {cd[COEF_W-1], cd} + r;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                px_reg[p] <= px_next[p];
                py_reg[p] <= py_next[p];
                pz_reg[p] <= pz_next[p];
                dr_reg[p] <= dr_next[p];
            end
            idx1_reg <= in_word.mesh_index;
        end
    end

    // Stage two: pairwise sums. (d + r) is scaled by 256 to Q16.16.
    logic signed [SUM_W-1:0] sxy_next [NUM_PLANES];
    logic signed [SUM_W-1:0] szd_next [NUM_PLANES];
    logic signed [SUM_W-1:0] sxy_reg  [NUM_PLANES];
    logic signed [SUM_W-1:0] szd_reg  [NUM_PLANES];
    logic [INDEX_W-1:0]      idx2_reg;

    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            sxy_next[p] = {{(SUM_W-PROD_W){px_reg[p][PROD_W-1]}}, px_reg[p]}
                        + {{(SUM_W-PROD_W){py_reg[p][PROD_W-1]}}, py_reg[p]};
            szd_next[p] = {{(SUM_W-PROD_W){pz_reg[p][PROD_W-1]}}, pz_reg[p]}
                        + {{(SUM_W-DR_W-8){dr_reg[p][DR_W-1]}}, dr_reg[p], 8'h00};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                sxy_reg[p] <= sxy_next[p];
                szd_reg[p] <= szd_next[p];
            end
            idx2_reg <= idx1_reg;
        end
    end

    // Stage three: the plane culls when the full sum is negative.
    logic [NUM_PLANES-1:0]   cull_next;
    logic [NUM_PLANES-1:0]   cull_reg;
    logic [INDEX_W-1:0]      idx3_reg;
    logic signed [SUM_W-1:0] total;

    always_comb begin
        total = '0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            total        = sxy_reg[p] + szd_reg[p];
            cull_next[p] = total[SUM_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            cull_reg <= cull_next;
            idx3_reg <= idx2_reg;
        end
    end

    // Output register.
    logic               vis_reg;
    logic [INDEX_W-1:0] idxo_reg;

    always_ff @(posedge aclk) begin
        if (rdyo && v3_reg) begin
            vis_reg  <= ~|cull_reg;
            idxo_reg <= idx3_reg;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tuser  = vis_reg;
    assign m_tdata  = idxo_reg;

`ifndef NO_ASSERTIONS
    // Input is refused only when every stage holds a word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && vo_reg))
        else $error("s_tready low with an empty stage");

    // A word in stage three that cannot move on is still there next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !rdyo) |=> v3_reg)
        else $error("stage three word lost during stall");

    // A stalled stage two word is neither dropped nor advanced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !rdy3) |=> (v2_reg && $stable(idx2_reg)))
        else $error("stage two word changed during stall");

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");
`endif

endmodule
